// ----- rtl/vld_pkg.sv -----
// shared types, constants and the permutation table for the voice leading distance block
// no dependencies; every other file in rtl/ refers to this package by scoped names
package vld_pkg;

  localparam int unsigned MAX_NOTES  = 4;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned DIST_W     = 9;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned NUM_LANES  = 24;
  localparam int unsigned GROUP_SIZE = 6;
  localparam int unsigned NUM_GROUPS = NUM_LANES / GROUP_SIZE;

  // marks a lane whose pairing leaves the valid notes
  localparam logic [DIST_W-1:0] COST_NONE = '1;

  typedef logic [NOTE_W-1:0]                           note_t;
  typedef logic [MAX_NOTES-1:0][NOTE_W-1:0]            note_vec_t;
  typedef logic [MAX_NOTES-1:0][MAX_NOTES-1:0][NOTE_W-1:0] diff_mat_t;
  typedef logic [MAX_NOTES-1:0][IDX_W-1:0]             perm_t;
  typedef logic [DIST_W-1:0]                           dist_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;         // smaller count
    logic [CNT_W-1:0] cl;        // larger count
    logic             a_longer;  // chord a holds the extra notes
    logic             empty;     // either chord has no notes
  } pair_info_t;

  // k-th permutation of 0..3 in lexicographic order (factorial number system)
  function automatic perm_t perm_of(input int unsigned k);
    perm_t           p;
    logic [3:0]      used;
    int unsigned     r;
    int unsigned     f;
    int unsigned     idx;
    int unsigned     cnt;
    logic            found;
    int unsigned     sel;
    r    = k;
    used = '0;
    p    = '0;
    for (int i = 0; i < 4; i++) begin
      f     = (i == 0) ? 6 : ((i == 1) ? 2 : 1);
      idx   = 0;
      cnt   = 0;
      found = 1'b0;
      sel   = 0;
      for (int t = 0; t < 3; t++) begin
        if (r >= f) begin
          r   = r - f;
          idx = idx + 1;
        end
      end
      for (int j = 0; j < 4; j++) begin
        if (!used[j]) begin
          if (cnt == idx && !found) begin
            sel   = j;
            found = 1'b1;
          end
          cnt = cnt + 1;
        end
      end
      p[i]      = IDX_W'(sel);
      used[sel] = 1'b1;
    end
    return p;
  endfunction

endpackage

// ----- rtl/voice_leading_distance.sv -----
// top level of the minimal voice leading distance block: four register stages, 24 permutation
// lanes, one item per cycle unless stalled; depends on vld_pkg, vld_diff, vld_lane, vld_merge.
//
// Each transaction on the input channel carries two chords of up to four MIDI notes and a note
// count per chord (counts above four act as four). The block returns one distance per
// transaction: zero if either chord is empty, otherwise the least total semitone movement over
// all one-to-one pairings of the first n notes (n = smaller count), plus, for every extra note
// of the larger chord, its distance to the nearest note of the smaller chord. A new transaction
// can be taken every cycle while the output is not stalled; the result passes through the four
// register stages of the pipeline: difference matrix, permutation lanes, first minimum level,
// final minimum and sum. Each stage moves on when it is empty or the stage after it moves, so
// the input keeps accepting while a result waits at the output as long as a stage is free.
module voice_leading_distance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [vld_pkg::CNT_W-1:0]        count_a,
  input  logic [vld_pkg::CNT_W-1:0]        count_b,
  input  logic [vld_pkg::NOTE_W-1:0]       note_a0,
  input  logic [vld_pkg::NOTE_W-1:0]       note_a1,
  input  logic [vld_pkg::NOTE_W-1:0]       note_a2,
  input  logic [vld_pkg::NOTE_W-1:0]       note_a3,
  input  logic [vld_pkg::NOTE_W-1:0]       note_b0,
  input  logic [vld_pkg::NOTE_W-1:0]       note_b1,
  input  logic [vld_pkg::NOTE_W-1:0]       note_b2,
  input  logic [vld_pkg::NOTE_W-1:0]       note_b3,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [vld_pkg::DIST_W-1:0]       distance
);

  // stage valid flags
  logic v1, v2, v3, v4;
  // stage advance enables, chained back from the output
  logic en1, en2, en3, en4;

  vld_pkg::note_vec_t  notes_a, notes_b;
  vld_pkg::diff_mat_t  diff;
  vld_pkg::pair_info_t info;
  vld_pkg::dist_t      lane_cost [vld_pkg::NUM_LANES];

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready  = en1;
  assign out_valid = v4;

  assign notes_a = {note_a3, note_a2, note_a1, note_a0};
  assign notes_b = {note_b3, note_b2, note_b1, note_b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: clamp counts, all 16 note differences
  vld_diff u_diff (
    .clk     (clk),
    .en      (en1),
    .count_a (count_a),
    .count_b (count_b),
    .notes_a (notes_a),
    .notes_b (notes_b),
    .diff    (diff),
    .info    (info)
  );

  // stage 2: one lane per pairing of four voices; lanes that reach past n report no cost
  for (genvar l = 0; l < vld_pkg::NUM_LANES; l++) begin : g_lane
    vld_lane #(
      .LANE (l)
    ) u_lane (
      .clk  (clk),
      .en   (en2),
      .diff (diff),
      .info (info),
      .cost (lane_cost[l])
    );
  end

  // stages 2 to 4: extra notes, minimum over lanes, final total
  vld_merge u_merge (
    .clk       (clk),
    .en2       (en2),
    .en3       (en3),
    .en4       (en4),
    .diff      (diff),
    .info      (info),
    .lane_cost (lane_cost),
    .distance  (distance)
  );

endmodule

// ----- rtl/vld_diff.sv -----
// input stage: clamps the counts and registers every note-to-note absolute difference
// depends on vld_pkg
module vld_diff (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vld_pkg::CNT_W-1:0]    count_a,
  input  logic [vld_pkg::CNT_W-1:0]    count_b,
  input  vld_pkg::note_vec_t           notes_a,
  input  vld_pkg::note_vec_t           notes_b,
  output vld_pkg::diff_mat_t           diff,
  output vld_pkg::pair_info_t          info
);

  localparam logic [vld_pkg::CNT_W-1:0] CNT_MAX = vld_pkg::CNT_W'(vld_pkg::MAX_NOTES);

  vld_pkg::diff_mat_t  diff_next;
  vld_pkg::pair_info_t info_next;
  logic [vld_pkg::CNT_W-1:0] ca, cb;

  always_comb begin
    ca = (count_a > CNT_MAX) ? CNT_MAX : count_a;
    cb = (count_b > CNT_MAX) ? CNT_MAX : count_b;
    info_next.n        = (ca < cb) ? ca : cb;
    info_next.cl       = (ca < cb) ? cb : ca;
    info_next.a_longer = (ca > cb);
    info_next.empty    = (ca == '0) || (cb == '0);
    for (int i = 0; i < vld_pkg::MAX_NOTES; i++) begin
      for (int j = 0; j < vld_pkg::MAX_NOTES; j++) begin
        diff_next[i][j] = (notes_a[i] > notes_b[j]) ? (notes_a[i] - notes_b[j])
                                                    : (notes_b[j] - notes_a[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
      info <= info_next;
    end
  end

endmodule

// ----- rtl/vld_lane.sv -----
// one lane: total movement of a single fixed pairing of chord a notes to chord b notes
// depends on vld_pkg (permutation table, types)
module vld_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  vld_pkg::diff_mat_t   diff,
  input  vld_pkg::pair_info_t  info,
  output vld_pkg::dist_t       cost
);

  localparam vld_pkg::perm_t PERM = vld_pkg::perm_of(LANE);

  vld_pkg::dist_t cost_next;
  vld_pkg::dist_t sum;
  logic           ok;

  always_comb begin
    sum = '0;
    ok  = 1'b1;
    for (int i = 0; i < vld_pkg::MAX_NOTES; i++) begin
      if (vld_pkg::CNT_W'(i) < info.n) begin
        // pairing must stay inside the first n notes of chord b
        if ({1'b0, PERM[i]} >= info.n) ok = 1'b0;
        sum = sum + vld_pkg::DIST_W'(diff[i][PERM[i]]);
      end
    end
    cost_next = ok ? sum : vld_pkg::COST_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) cost <= cost_next;
  end

endmodule

// ----- rtl/vld_merge.sv -----
// merge stages: nearest-note cost of the extra notes, grouped minimum over lanes, final sum
// depends on vld_pkg
module vld_merge (
  input  logic                 clk,
  input  logic                 en2,
  input  logic                 en3,
  input  logic                 en4,
  input  vld_pkg::diff_mat_t   diff,
  input  vld_pkg::pair_info_t  info,
  input  vld_pkg::dist_t       lane_cost [vld_pkg::NUM_LANES],
  output vld_pkg::dist_t       distance
);

  vld_pkg::dist_t extra2, extra2_next;
  logic           empty2, empty3;
  vld_pkg::dist_t extra3;
  vld_pkg::dist_t grp_min [vld_pkg::NUM_GROUPS];
  vld_pkg::dist_t grp_min_next [vld_pkg::NUM_GROUPS];
  vld_pkg::dist_t distance_next;

  // extra notes of the longer chord, each to its nearest note of the shorter one
  always_comb begin
    logic [vld_pkg::NOTE_W-1:0] m;
    logic [vld_pkg::NOTE_W-1:0] dv;
    extra2_next = '0;
    for (int i = 0; i < vld_pkg::MAX_NOTES; i++) begin
      m = '1;
      for (int j = 0; j < vld_pkg::MAX_NOTES; j++) begin
        dv = info.a_longer ? diff[i][j] : diff[j][i];
        if (vld_pkg::CNT_W'(j) < info.n && dv < m) m = dv;
      end
      if (vld_pkg::CNT_W'(i) >= info.n && vld_pkg::CNT_W'(i) < info.cl)
        extra2_next = extra2_next + vld_pkg::DIST_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      extra2 <= extra2_next;
      empty2 <= info.empty;
    end
  end

  // first level of the minimum tree
  always_comb begin
    for (int g = 0; g < vld_pkg::NUM_GROUPS; g++) begin
      grp_min_next[g] = lane_cost[g*vld_pkg::GROUP_SIZE];
      for (int k = 1; k < vld_pkg::GROUP_SIZE; k++) begin
        if (lane_cost[g*vld_pkg::GROUP_SIZE + k] < grp_min_next[g])
          grp_min_next[g] = lane_cost[g*vld_pkg::GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      grp_min <= grp_min_next;
      extra3  <= extra2;
      empty3  <= empty2;
    end
  end

  always_comb begin
    vld_pkg::dist_t best;
    best = grp_min[0];
    for (int g = 1; g < vld_pkg::NUM_GROUPS; g++) begin
      if (grp_min[g] < best) best = grp_min[g];
    end
    distance_next = empty3 ? '0 : vld_pkg::DIST_W'(best + extra3);
  end

  always_ff @(posedge clk) begin
    if (en4) distance <= distance_next;
  end

endmodule

// ----- rtl/vld_checker.sv -----
// port-level checks for voice_leading_distance, bound to the top level below
// depends on vld_pkg for widths only
module vld_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vld_pkg::DIST_W-1:0]  distance
);

  // a result held by the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("result changed while stalled");

  // four notes of 127 semitones at most
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance <= 9'd508)
    else $error("distance out of range");

  // with no result waiting the pipeline can always take a transaction
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind voice_leading_distance vld_checker u_vld_checker (.*);
